// ===== rtl/jbd_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package jbd_pkg;

    localparam logic [7:0] ESC_BYTE     = 8'hFF;
    localparam logic [7:0] STUFF_CODE   = 8'h00;
    localparam logic [7:0] RESERVE_CODE = 8'h01;
    localparam logic [7:0] SDNORM_CODE  = 8'h02;
    localparam logic [7:0] SDRST_CODE   = 8'h03;
    localparam logic [7:0] ABORT_CODE   = 8'h04;
    localparam logic [7:0] NEWLEN_CODE  = 8'h05;
    localparam logic [7:0] ATMOVE_CODE  = 8'h06;
    localparam logic [7:0] COMMENT_CODE = 8'h07;

    typedef enum logic [1:0] {
        MARKER_NONE    = 2'd0,
        MARKER_NEWLEN  = 2'd1,
        MARKER_ATMOVE  = 2'd2,
        MARKER_COMMENT = 2'd3
    } marker_t;

    typedef struct packed {
        logic [7:0] bid_byte;
        logic       new_stripe;
    } bid_item_t;

    typedef struct packed {
        logic [7:0] scd_byte;
        logic       scd_valid;
        logic [1:0] marker_event;
        logic [2:0] end_status;
        logic       decode_error;
        logic       in_stripe;
    } scd_item_t;

endpackage

`default_nettype wire

// ===== rtl/jbd_in_stage.sv =====
`timescale 1ns / 1ps
`default_nettype none

module jbd_in_stage (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               raw_valid,
    output logic                    raw_stall,
    input  wire jbd_pkg::bid_item_t raw_item,
    input  wire logic               advance,
    output logic                    held_valid,
    output jbd_pkg::bid_item_t      held_item
);

    logic               held_valid_reg;
    jbd_pkg::bid_item_t held_item_reg;

    // hold the byte until the decoder takes it
    assign raw_stall  = held_valid_reg && !advance;
    assign held_valid = held_valid_reg;
    assign held_item  = held_item_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_valid_reg <= 1'b0;
        end
        else if (!raw_stall)
        begin
            held_valid_reg <= raw_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!raw_stall && raw_valid)
        begin
            held_item_reg <= raw_item;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/jbd_decode.sv =====
`timescale 1ns / 1ps
`default_nettype none

module jbd_decode (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               held_valid,
    input  wire jbd_pkg::bid_item_t held_item,
    input  wire logic               out_ready,
    output logic                    advance,
    output logic                    result_load,
    output jbd_pkg::scd_item_t      result
);

    logic       escape_pending_reg;
    logic       escape_pending_next;
    logic       stripe_active_reg;
    logic       stripe_active_next;
    logic [2:0] end_code_bits_reg;
    logic [2:0] end_code_bits_next;
    logic       error_seen_reg;
    logic       error_seen_next;
    logic       has_result;

    always_comb
    begin
        logic [7:0]       data;
        logic             valid;
        jbd_pkg::marker_t marker;
        logic [7:0]       b;

        b      = held_item.bid_byte;
        data   = 8'h00;
        valid  = 1'b1;
        marker = jbd_pkg::MARKER_NONE;
        has_result = 1'b1;

        escape_pending_next = escape_pending_reg;
        stripe_active_next  = stripe_active_reg;
        end_code_bits_next  = held_item.new_stripe ? 3'b000 : end_code_bits_reg;
        error_seen_next     = held_item.new_stripe ? 1'b0 : error_seen_reg;

        if (!escape_pending_reg)
        begin
            if (b == jbd_pkg::ESC_BYTE)
            begin
                escape_pending_next = 1'b1;
                has_result          = 1'b0;
            end
            else
            begin
                data = b;
            end
        end
        else
        begin
            escape_pending_next = 1'b0;
            if (b == jbd_pkg::STUFF_CODE)
            begin
                data = 8'hFF;
            end
            else if (b inside {jbd_pkg::SDNORM_CODE, jbd_pkg::SDRST_CODE,
                               jbd_pkg::ABORT_CODE})
            begin
                end_code_bits_next = end_code_bits_next | b[2:0];
            end
            else if (b inside {jbd_pkg::NEWLEN_CODE, jbd_pkg::ATMOVE_CODE,
                               jbd_pkg::COMMENT_CODE} && !stripe_active_reg)
            begin
                valid = 1'b0;
                case (b)
                    jbd_pkg::NEWLEN_CODE: marker = jbd_pkg::MARKER_NEWLEN;
                    jbd_pkg::ATMOVE_CODE: marker = jbd_pkg::MARKER_ATMOVE;
                    default:              marker = jbd_pkg::MARKER_COMMENT;
                endcase
            end
            else
            begin
                error_seen_next = 1'b1;
                data            = 8'hFF;
            end
        end

        // track the stripe flag only on returned bytes
        if (has_result && valid)
        begin
            stripe_active_next = (end_code_bits_next == 3'b000) && !error_seen_next;
        end

        result.scd_byte     = data;
        result.scd_valid    = valid;
        result.marker_event = marker;
        result.end_status   = end_code_bits_next;
        result.decode_error = error_seen_next;
        result.in_stripe    = stripe_active_next;
    end

    // a held escape needs no output slot
    assign advance     = held_valid && (out_ready || !has_result);
    assign result_load = advance && has_result;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            escape_pending_reg <= 1'b0;
            stripe_active_reg  <= 1'b0;
            end_code_bits_reg  <= 3'b000;
            error_seen_reg     <= 1'b0;
        end
        else if (advance)
        begin
            escape_pending_reg <= escape_pending_next;
            stripe_active_reg  <= stripe_active_next;
            end_code_bits_reg  <= end_code_bits_next;
            error_seen_reg     <= error_seen_next;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/jbd_out_stage.sv =====
`timescale 1ns / 1ps
`default_nettype none

module jbd_out_stage (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               result_load,
    input  wire jbd_pkg::scd_item_t result,
    output logic                    out_ready,
    output logic                    dec_valid,
    input  wire logic               dec_stall,
    output jbd_pkg::scd_item_t      dec_item
);

    logic               dec_valid_reg;
    jbd_pkg::scd_item_t dec_item_reg;

    assign out_ready = !dec_valid_reg || !dec_stall;
    assign dec_valid = dec_valid_reg;
    assign dec_item  = dec_item_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dec_valid_reg <= 1'b0;
        end
        else if (out_ready)
        begin
            dec_valid_reg <= result_load;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_ready && result_load)
        begin
            dec_item_reg <= result;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/jbig_bid_destuffer_top.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Channel   Handshake             Payload
// raw       raw_valid/raw_stall   raw_item (bid_item_t): bid_byte, new_stripe
// dec       dec_valid/dec_stall   dec_item (scd_item_t): scd_byte .. in_stripe
//
// One byte is taken every clock while raw_stall is low. Its result passes through
// the input register and then the result register around the decoder before it
// is offered on dec.
// A leading 0xFF gives no transaction on dec. Reset clears all status.
// A stall on dec holds the result register and, once the input register is
// also full with a byte that yields a result, stalls raw.

module jbig_bid_destuffer_top (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               raw_valid,
    output logic                    raw_stall,
    input  wire jbd_pkg::bid_item_t raw_item,
    output logic                    dec_valid,
    input  wire logic               dec_stall,
    output jbd_pkg::scd_item_t      dec_item
);

    logic               held_valid;
    jbd_pkg::bid_item_t held_item;
    logic               advance;
    logic               out_ready;
    logic               result_load;
    jbd_pkg::scd_item_t result;

    jbd_in_stage u_in_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .raw_valid  (raw_valid),
        .raw_stall  (raw_stall),
        .raw_item   (raw_item),
        .advance    (advance),
        .held_valid (held_valid),
        .held_item  (held_item)
    );

    jbd_decode u_decode (
        .clk         (clk),
        .rst_n       (rst_n),
        .held_valid  (held_valid),
        .held_item   (held_item),
        .out_ready   (out_ready),
        .advance     (advance),
        .result_load (result_load),
        .result      (result)
    );

    jbd_out_stage u_out_stage (
        .clk         (clk),
        .rst_n       (rst_n),
        .result_load (result_load),
        .result      (result),
        .out_ready   (out_ready),
        .dec_valid   (dec_valid),
        .dec_stall   (dec_stall),
        .dec_item    (dec_item)
    );

endmodule

`default_nettype wire
